// ===== design/round_robin_task_scheduler_unit_defines.svh =====
// Assertion macros for the round-robin task scheduler unit.
// Used by the port checker; depends on a clock i_clk and reset i_rst_n in scope.
`ifndef ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH
`define ROUND_ROBIN_TASK_SCHEDULER_UNIT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define RRTS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("scheduler check failed");

// The consequent must hold in the cycle after the antecedent.
`define RRTS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("scheduler check failed");

`endif

// ===== design/rrts_pkg.sv =====
// Shared types and constants of the round-robin task scheduler.
// No dependencies; used by the controller, datapath and top level.
`default_nettype none
package rrts_pkg;

    localparam int TASK_SLOTS_DEF = 8;

    localparam logic [2:0] OP_PREEMPT = 3'd0;
    localparam logic [2:0] OP_CREATE_USER = 3'd1;
    localparam logic [2:0] OP_CREATE_KERNEL = 3'd2;
    localparam logic [2:0] OP_KILL = 3'd3;
    localparam logic [2:0] OP_SLEEP = 3'd4;
    localparam logic [2:0] OP_EXIT = 3'd5;
    localparam logic [2:0] OP_FAULT = 3'd6;

    localparam logic [1:0] ST_DEAD = 2'd0;
    localparam logic [1:0] ST_READY = 2'd1;
    localparam logic [1:0] ST_RUNNING = 2'd2;
    localparam logic [1:0] ST_BLOCKED = 2'd3;

    localparam logic [4:0] CMD_NONE = 5'd0;
    localparam logic [4:0] CMD_LATCH = 5'd1;
    localparam logic [4:0] CMD_SAVE = 5'd2;
    localparam logic [4:0] CMD_WALK_INIT = 5'd3;
    localparam logic [4:0] CMD_WALK_STEP = 5'd4;
    localparam logic [4:0] CMD_RM_INIT_CUR = 5'd5;
    localparam logic [4:0] CMD_RM_INIT_PREV = 5'd6;
    localparam logic [4:0] CMD_RM_INIT_SEL = 5'd7;
    localparam logic [4:0] CMD_RM_STEP = 5'd8;
    localparam logic [4:0] CMD_SCAN_DEAD = 5'd9;
    localparam logic [4:0] CMD_SCAN_ID = 5'd10;
    localparam logic [4:0] CMD_CREATE = 5'd11;
    localparam logic [4:0] CMD_REFUSE = 5'd12;
    localparam logic [4:0] CMD_SET_DEAD = 5'd13;
    localparam logic [4:0] CMD_SLP1 = 5'd14;
    localparam logic [4:0] CMD_SLP2 = 5'd15;
    localparam logic [4:0] CMD_TAKE = 5'd16;
    localparam logic [4:0] CMD_RESUME = 5'd17;

    // Ceiling of ms/100 is floor(((ms + 99) >> 2) / 25), done by reciprocal.
    localparam logic [31:0] SLEEP_ROUND = 32'd99;
    localparam logic [31:0] RECIP_25 = 32'd2748779070;
    localparam int RECIP_SHIFT = 36;

    typedef struct packed {
        logic [4:0] code;
        logic       load;
    } t_cmd;

    typedef struct packed {
        logic [2:0] op;
        logic       walk_end;
        logic       walk_hit;
        logic       rm_hit;
        logic       scan_end;
        logic       dead_hit;
        logic       id_hit;
        logic       kill_bad;
        logic       cur_running;
    } t_stat;

endpackage
`default_nettype wire

// ===== design/rrts_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// No dependencies.
`default_nettype none
module rrts_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 8
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== design/rrts_ctrl.sv =====
// Controller state machine of the task scheduler: sequences scans and list walks.
// Depends on rrts_pkg; drives commands to rrts_dpath and reads its status.
`default_nettype none
module rrts_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_valid,
    output logic               o_stall,
    output logic               o_valid,
    input  wire logic          i_stall,
    input  wire rrts_pkg::t_stat i_stat,
    output rrts_pkg::t_cmd     o_cmd
);

    localparam logic [4:0] S_IDLE = 5'd0;
    localparam logic [4:0] S_DEC = 5'd1;
    localparam logic [4:0] S_SAVE = 5'd2;
    localparam logic [4:0] S_WINIT = 5'd3;
    localparam logic [4:0] S_WALK = 5'd4;
    localparam logic [4:0] S_TAKE = 5'd5;
    localparam logic [4:0] S_RMPRV = 5'd6;
    localparam logic [4:0] S_RM = 5'd7;
    localparam logic [4:0] S_RESUME = 5'd8;
    localparam logic [4:0] S_RD = 5'd9;
    localparam logic [4:0] S_DONE = 5'd10;
    localparam logic [4:0] S_SCANC = 5'd11;
    localparam logic [4:0] S_CREATE = 5'd12;
    localparam logic [4:0] S_REFUSE = 5'd13;
    localparam logic [4:0] S_SCANK = 5'd14;
    localparam logic [4:0] S_KCHK = 5'd15;
    localparam logic [4:0] S_SLP1 = 5'd16;
    localparam logic [4:0] S_SLP2 = 5'd17;
    localparam logic [4:0] S_EXIT = 5'd18;
    localparam logic [4:0] S_KILLED = 5'd19;

    localparam logic RET_DEAD = 1'b0;
    localparam logic RET_RESUME = 1'b1;

    logic [4:0] r_state, n_state;
    logic       r_ret, n_ret;
    logic       r_valid, n_valid;

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_valid;

    always_comb begin
        n_state = r_state;
        n_ret = r_ret;
        n_valid = r_valid;
        o_cmd.code = rrts_pkg::CMD_NONE;
        o_cmd.load = 1'b0;
        if (r_valid && !i_stall) begin
            n_valid = 1'b0;
        end
        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.code = rrts_pkg::CMD_LATCH;
                    n_state = S_DEC;
                end
            end
            S_DEC: begin
                case (i_stat.op)
                    rrts_pkg::OP_PREEMPT: n_state = S_SAVE;
                    rrts_pkg::OP_CREATE_USER: n_state = S_SCANC;
                    rrts_pkg::OP_CREATE_KERNEL: n_state = S_SCANC;
                    rrts_pkg::OP_KILL: n_state = S_SCANK;
                    rrts_pkg::OP_SLEEP: n_state = S_SLP1;
                    rrts_pkg::OP_EXIT: n_state = S_EXIT;
                    rrts_pkg::OP_FAULT: n_state = S_EXIT;
                    default: n_state = S_DONE;
                endcase
            end
            S_SAVE: begin
                o_cmd.code = rrts_pkg::CMD_SAVE;
                n_state = S_WINIT;
            end
            S_WINIT: begin
                o_cmd.code = rrts_pkg::CMD_WALK_INIT;
                n_state = S_WALK;
            end
            S_WALK: begin
                o_cmd.code = rrts_pkg::CMD_WALK_STEP;
                if (i_stat.walk_end) begin
                    n_state = S_RMPRV;
                end else if (i_stat.walk_hit) begin
                    n_state = S_TAKE;
                end
            end
            S_TAKE: begin
                o_cmd.code = rrts_pkg::CMD_TAKE;
                n_state = S_RD;
            end
            S_RMPRV: begin
                o_cmd.code = rrts_pkg::CMD_RM_INIT_PREV;
                n_ret = RET_RESUME;
                n_state = S_RM;
            end
            S_RM: begin
                o_cmd.code = rrts_pkg::CMD_RM_STEP;
                if (i_stat.walk_end || i_stat.rm_hit) begin
                    n_state = (r_ret == RET_RESUME) ? S_RESUME : S_KILLED;
                end
            end
            S_RESUME: begin
                o_cmd.code = rrts_pkg::CMD_RESUME;
                n_state = S_RD;
            end
            S_RD: begin
                n_state = S_DONE;
            end
            S_DONE: begin
                if (!r_valid || !i_stall) begin
                    o_cmd.load = 1'b1;
                    n_valid = 1'b1;
                    n_state = S_IDLE;
                end
            end
            S_SCANC: begin
                o_cmd.code = rrts_pkg::CMD_SCAN_DEAD;
                if (i_stat.scan_end) begin
                    n_state = S_REFUSE;
                end else if (i_stat.dead_hit) begin
                    n_state = S_CREATE;
                end
            end
            S_CREATE: begin
                o_cmd.code = rrts_pkg::CMD_CREATE;
                n_state = S_DONE;
            end
            S_REFUSE: begin
                o_cmd.code = rrts_pkg::CMD_REFUSE;
                n_state = S_DONE;
            end
            S_SCANK: begin
                o_cmd.code = rrts_pkg::CMD_SCAN_ID;
                if (i_stat.scan_end) begin
                    n_state = S_REFUSE;
                end else if (i_stat.id_hit) begin
                    n_state = S_KCHK;
                end
            end
            S_KCHK: begin
                if (i_stat.kill_bad) begin
                    n_state = S_REFUSE;
                end else begin
                    o_cmd.code = rrts_pkg::CMD_RM_INIT_SEL;
                    n_ret = RET_DEAD;
                    n_state = S_RM;
                end
            end
            S_SLP1: begin
                if (i_stat.cur_running) begin
                    o_cmd.code = rrts_pkg::CMD_SLP1;
                    n_state = S_SLP2;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_SLP2: begin
                o_cmd.code = rrts_pkg::CMD_SLP2;
                n_state = S_DONE;
            end
            S_EXIT: begin
                o_cmd.code = rrts_pkg::CMD_RM_INIT_CUR;
                n_ret = RET_DEAD;
                n_state = S_RM;
            end
            S_KILLED: begin
                o_cmd.code = rrts_pkg::CMD_SET_DEAD;
                n_state = (i_stat.op == rrts_pkg::OP_FAULT) ? S_SAVE : S_DONE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_ret <= RET_DEAD;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ret <= n_ret;
            r_valid <= n_valid;
        end
    end

endmodule
`default_nettype wire

// ===== design/rrts_dpath.sv =====
// Datapath of the task scheduler: slot table, ready list, sleep math, result register.
// Depends on rrts_pkg and rrts_ram; commanded by rrts_ctrl.
`default_nettype none
module rrts_dpath #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire rrts_pkg::t_cmd i_cmd,
    output rrts_pkg::t_stat     o_stat,
    input  wire logic [2:0]     i_opcode,
    input  wire logic [47:0]    i_now_tick,
    input  wire logic [63:0]    i_context_word,
    input  wire logic [63:0]    i_user_stack_word,
    input  wire logic [15:0]    i_target_id,
    input  wire logic [31:0]    i_sleep_ms,
    output logic                o_status,
    output logic [15:0]         o_new_task_id,
    output logic [2:0]          o_running_slot,
    output logic [15:0]         o_running_id,
    output logic                o_switched,
    output logic [63:0]         o_next_context,
    output logic [63:0]         o_next_user_stack,
    output logic                o_restore_user_stack
);

    localparam int SW = $clog2(TASK_SLOTS);
    localparam int LW = $clog2(TASK_SLOTS + 1);
    localparam logic [LW-1:0] NIL = LW'(TASK_SLOTS);

    logic [1:0]    r_st [TASK_SLOTS];
    logic [1:0]    n_st [TASK_SLOTS];
    logic [15:0]   r_id [TASK_SLOTS];
    logic [15:0]   n_id [TASK_SLOTS];
    logic          r_usr [TASK_SLOTS];
    logic          n_usr [TASK_SLOTS];
    logic [47:0]   r_wake [TASK_SLOTS];
    logic [47:0]   n_wake [TASK_SLOTS];
    logic [LW-1:0] r_link [TASK_SLOTS];
    logic [LW-1:0] n_link [TASK_SLOTS];
    logic          r_cvld [TASK_SLOTS];
    logic          n_cvld [TASK_SLOTS];
    logic          r_uvld [TASK_SLOTS];
    logic          n_uvld [TASK_SLOTS];

    logic [LW-1:0] r_head, n_head, r_tail, n_tail;
    logic [SW-1:0] r_cur, n_cur, r_prev, n_prev, r_sel, n_sel, r_tgt, n_tgt;
    logic [15:0]   r_ctr, n_ctr;
    logic [LW-1:0] r_p, n_p, r_c, n_c, r_n, n_n, r_i, n_i;
    logic          r_res_status, n_res_status, r_res_sw, n_res_sw;
    logic [15:0]   r_res_id, n_res_id;
    logic          r_pre, n_pre, r_rest, n_rest;

    logic [2:0]    r_op;
    logic [47:0]   r_now;
    logic [63:0]   r_ctx, r_ustk;
    logic [15:0]   r_tid;
    logic [31:0]   r_ms;
    logic [62:0]   r_prod;
    logic          r_rd_cv, r_rd_uv;

    logic [SW-1:0] c_idx, i_idx;
    logic          walk_end, scan_end, woke, ready, rm_hit;
    logic [32:0]   ms_round;
    logic [62:0]   prod_c;
    logic [48:0]   wake_sum;
    logic [47:0]   wake_sat;
    logic          ctx_we, ustk_we;
    logic [SW-1:0] ram_waddr;
    logic [63:0]   ustk_wdata, ctx_q, ustk_q, ctx_val, ustk_val;
    logic [SW+2:0] cur_ext;

    assign c_idx = r_c[SW-1:0];
    assign i_idx = r_i[SW-1:0];
    assign walk_end = (r_n == NIL) || !(r_c < NIL);
    assign scan_end = (r_i == NIL);
    assign woke = (r_st[c_idx] == rrts_pkg::ST_BLOCKED) && (r_now >= r_wake[c_idx]);
    assign ready = woke || (r_st[c_idx] == rrts_pkg::ST_READY);
    assign rm_hit = (c_idx == r_tgt);

    assign ms_round = {1'b0, r_ms} + {1'b0, rrts_pkg::SLEEP_ROUND};
    assign prod_c = {32'd0, ms_round[32:2]} * {31'd0, rrts_pkg::RECIP_25};
    assign wake_sum = {1'b0, r_now} + 49'(r_prod[62:rrts_pkg::RECIP_SHIFT]);
    assign wake_sat = wake_sum[48] ? {48{1'b1}} : wake_sum[47:0];

    assign o_stat.op = r_op;
    assign o_stat.walk_end = walk_end;
    assign o_stat.walk_hit = !walk_end && ready;
    assign o_stat.rm_hit = !walk_end && rm_hit;
    assign o_stat.scan_end = scan_end;
    assign o_stat.dead_hit = !scan_end && (r_st[i_idx] == rrts_pkg::ST_DEAD);
    assign o_stat.id_hit = !scan_end && (r_id[i_idx] == r_tid)
                           && (r_st[i_idx] != rrts_pkg::ST_DEAD);
    assign o_stat.kill_bad = (r_sel == '0) || (r_sel == r_cur);
    assign o_stat.cur_running = (r_st[r_cur] == rrts_pkg::ST_RUNNING);

    assign ctx_we = (i_cmd.code == rrts_pkg::CMD_SAVE) || (i_cmd.code == rrts_pkg::CMD_CREATE);
    assign ustk_we = ((i_cmd.code == rrts_pkg::CMD_SAVE) && r_usr[r_cur])
                     || (i_cmd.code == rrts_pkg::CMD_CREATE);
    assign ram_waddr = (i_cmd.code == rrts_pkg::CMD_SAVE) ? r_cur : r_sel;
    assign ustk_wdata = ((i_cmd.code == rrts_pkg::CMD_CREATE)
                         && (r_op != rrts_pkg::OP_CREATE_USER)) ? 64'd0 : r_ustk;

    rrts_ram #(.WIDTH(64), .DEPTH(TASK_SLOTS)) u_ctx_ram (
        .i_clk   (i_clk),
        .i_we    (ctx_we),
        .i_waddr (ram_waddr),
        .i_wdata (r_ctx),
        .i_raddr (r_sel),
        .o_rdata (ctx_q)
    );

    rrts_ram #(.WIDTH(64), .DEPTH(TASK_SLOTS)) u_ustk_ram (
        .i_clk   (i_clk),
        .i_we    (ustk_we),
        .i_waddr (ram_waddr),
        .i_wdata (ustk_wdata),
        .i_raddr (r_sel),
        .o_rdata (ustk_q)
    );

    assign ctx_val = r_rd_cv ? ctx_q : 64'd0;
    assign ustk_val = r_rd_uv ? ustk_q : 64'd0;
    assign cur_ext = (SW + 3)'(r_cur);

    always_comb begin
        n_st = r_st;
        n_id = r_id;
        n_usr = r_usr;
        n_wake = r_wake;
        n_link = r_link;
        n_cvld = r_cvld;
        n_uvld = r_uvld;
        n_head = r_head;
        n_tail = r_tail;
        n_cur = r_cur;
        n_prev = r_prev;
        n_sel = r_sel;
        n_tgt = r_tgt;
        n_ctr = r_ctr;
        n_p = r_p;
        n_c = r_c;
        n_n = r_n;
        n_i = r_i;
        n_res_status = r_res_status;
        n_res_sw = r_res_sw;
        n_res_id = r_res_id;
        n_pre = r_pre;
        n_rest = r_rest;
        if (ctx_we) begin
            n_cvld[ram_waddr] = 1'b1;
        end
        if (ustk_we) begin
            n_uvld[ram_waddr] = 1'b1;
        end
        case (i_cmd.code)
            rrts_pkg::CMD_LATCH: begin
                n_res_status = 1'b0;
                n_res_sw = 1'b0;
                n_res_id = 16'd0;
                n_pre = 1'b0;
                n_rest = 1'b0;
                n_i = '0;
            end
            rrts_pkg::CMD_SAVE: begin
                n_prev = r_cur;
                if (r_st[r_cur] == rrts_pkg::ST_RUNNING) begin
                    n_st[r_cur] = rrts_pkg::ST_READY;
                    n_link[r_cur] = NIL;
                    if (r_head == NIL) begin
                        n_head = LW'(r_cur);
                    end else if (r_tail < NIL) begin
                        n_link[r_tail[SW-1:0]] = LW'(r_cur);
                    end
                    n_tail = LW'(r_cur);
                end
            end
            rrts_pkg::CMD_WALK_INIT: begin
                n_p = NIL;
                n_c = r_head;
                n_n = '0;
            end
            rrts_pkg::CMD_RM_INIT_CUR, rrts_pkg::CMD_RM_INIT_PREV,
            rrts_pkg::CMD_RM_INIT_SEL: begin
                n_p = NIL;
                n_c = r_head;
                n_n = '0;
                if (i_cmd.code == rrts_pkg::CMD_RM_INIT_CUR) begin
                    n_tgt = r_cur;
                end else if (i_cmd.code == rrts_pkg::CMD_RM_INIT_PREV) begin
                    n_tgt = r_prev;
                end else begin
                    n_tgt = r_sel;
                end
            end
            rrts_pkg::CMD_WALK_STEP, rrts_pkg::CMD_RM_STEP: begin
                if (!walk_end) begin
                    if (i_cmd.code == rrts_pkg::CMD_WALK_STEP && woke) begin
                        n_st[c_idx] = rrts_pkg::ST_READY;
                    end
                    if ((i_cmd.code == rrts_pkg::CMD_WALK_STEP) ? ready : rm_hit) begin
                        if (r_p == NIL) begin
                            n_head = r_link[c_idx];
                        end else begin
                            n_link[r_p[SW-1:0]] = r_link[c_idx];
                        end
                        if (r_tail == r_c) begin
                            n_tail = r_p;
                        end
                        n_link[c_idx] = NIL;
                        n_sel = (i_cmd.code == rrts_pkg::CMD_WALK_STEP) ? c_idx : r_sel;
                    end else begin
                        n_p = r_c;
                        n_c = r_link[c_idx];
                        n_n = r_n + 1'b1;
                    end
                end
            end
            rrts_pkg::CMD_SCAN_DEAD, rrts_pkg::CMD_SCAN_ID: begin
                if (!scan_end) begin
                    if ((i_cmd.code == rrts_pkg::CMD_SCAN_DEAD) ? o_stat.dead_hit
                                                                : o_stat.id_hit) begin
                        n_sel = i_idx;
                    end else begin
                        n_i = r_i + 1'b1;
                    end
                end
            end
            rrts_pkg::CMD_CREATE: begin
                n_id[r_sel] = r_ctr;
                n_ctr = r_ctr + 16'd1;
                n_res_id = r_ctr;
                n_st[r_sel] = rrts_pkg::ST_READY;
                n_wake[r_sel] = 48'd0;
                n_usr[r_sel] = (r_op == rrts_pkg::OP_CREATE_USER);
                n_link[r_sel] = NIL;
                if (r_head == NIL) begin
                    n_head = LW'(r_sel);
                end else if (r_tail < NIL) begin
                    n_link[r_tail[SW-1:0]] = LW'(r_sel);
                end
                n_tail = LW'(r_sel);
            end
            rrts_pkg::CMD_REFUSE: begin
                n_res_status = 1'b1;
            end
            rrts_pkg::CMD_SET_DEAD: begin
                n_st[r_tgt] = rrts_pkg::ST_DEAD;
            end
            rrts_pkg::CMD_SLP2: begin
                n_wake[r_cur] = wake_sat;
                n_st[r_cur] = rrts_pkg::ST_BLOCKED;
                n_link[r_cur] = NIL;
                if (r_head == NIL) begin
                    n_head = LW'(r_cur);
                end else if (r_tail < NIL) begin
                    n_link[r_tail[SW-1:0]] = LW'(r_cur);
                end
                n_tail = LW'(r_cur);
            end
            rrts_pkg::CMD_TAKE: begin
                n_cur = r_sel;
                n_st[r_sel] = rrts_pkg::ST_RUNNING;
                n_res_sw = (r_sel != r_prev);
                n_pre = 1'b1;
                n_rest = 1'b1;
            end
            rrts_pkg::CMD_RESUME: begin
                n_st[r_prev] = rrts_pkg::ST_RUNNING;
                n_sel = r_prev;
                n_pre = 1'b1;
                n_rest = 1'b0;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < TASK_SLOTS; k++) begin
                r_st[k] <= (k == 0) ? rrts_pkg::ST_RUNNING : rrts_pkg::ST_DEAD;
                r_id[k] <= 16'd0;
                r_usr[k] <= 1'b0;
                r_wake[k] <= 48'd0;
                r_link[k] <= NIL;
                r_cvld[k] <= 1'b0;
                r_uvld[k] <= 1'b0;
            end
            r_head <= NIL;
            r_tail <= NIL;
            r_cur <= '0;
            r_prev <= '0;
            r_sel <= '0;
            r_tgt <= '0;
            r_ctr <= 16'd1;
            r_p <= NIL;
            r_c <= NIL;
            r_n <= '0;
            r_i <= '0;
            r_res_status <= 1'b0;
            r_res_sw <= 1'b0;
            r_res_id <= 16'd0;
            r_pre <= 1'b0;
            r_rest <= 1'b0;
        end else begin
            r_st <= n_st;
            r_id <= n_id;
            r_usr <= n_usr;
            r_wake <= n_wake;
            r_link <= n_link;
            r_cvld <= n_cvld;
            r_uvld <= n_uvld;
            r_head <= n_head;
            r_tail <= n_tail;
            r_cur <= n_cur;
            r_prev <= n_prev;
            r_sel <= n_sel;
            r_tgt <= n_tgt;
            r_ctr <= n_ctr;
            r_p <= n_p;
            r_c <= n_c;
            r_n <= n_n;
            r_i <= n_i;
            r_res_status <= n_res_status;
            r_res_sw <= n_res_sw;
            r_res_id <= n_res_id;
            r_pre <= n_pre;
            r_rest <= n_rest;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_cv <= r_cvld[r_sel];
        r_rd_uv <= r_uvld[r_sel];
        if (i_cmd.code == rrts_pkg::CMD_LATCH) begin
            r_op <= i_opcode;
            r_now <= i_now_tick;
            r_ctx <= i_context_word;
            r_ustk <= i_user_stack_word;
            r_tid <= i_target_id;
            r_ms <= i_sleep_ms;
        end
        if (i_cmd.code == rrts_pkg::CMD_SLP1) begin
            r_prod <= prod_c;
        end
        if (i_cmd.load) begin
            o_status <= r_res_status;
            o_new_task_id <= r_res_id;
            o_running_slot <= cur_ext[2:0];
            o_running_id <= r_id[r_cur];
            o_switched <= r_res_sw;
            o_next_context <= r_pre ? ctx_val : 64'd0;
            o_next_user_stack <= r_pre ? ustk_val : 64'd0;
            o_restore_user_stack <= r_pre && r_rest && r_usr[r_sel] && (ustk_val != 64'd0);
        end
    end

endmodule
`default_nettype wire

// ===== design/round_robin_task_scheduler_unit.sv =====
// Round-robin task scheduler top level: joins the controller and the datapath.
// Depends on rrts_pkg, rrts_ctrl and rrts_dpath.
//
// One scheduling event is taken at a time and gives one result beat. An event keeps the
// input stalled from the accepting cycle until its result beat is offered, and the next
// event may already be accepted in the cycle that beat is offered. Slot scans and
// ready-list walks visit one slot per cycle and set the cost: a preempt is quickest when
// the head of the list is ready, slower the further down the first ready entry lies,
// and slowest when the current task resumes. A create scans the slots for a dead one;
// a kill scans for the target and may then walk the list to unlink it. A result beat
// that is still stalled holds the block in its last cycle. Slot contexts and user stacks
// live in two RAMs; there is no clearing pass after reset.
`default_nettype none
module round_robin_task_scheduler_unit #(
    parameter int TASK_SLOTS = rrts_pkg::TASK_SLOTS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_valid,
    output logic             o_stall,
    input  wire logic [2:0]  i_opcode,
    input  wire logic [47:0] i_now_tick,
    input  wire logic [63:0] i_context_word,
    input  wire logic [63:0] i_user_stack_word,
    input  wire logic [15:0] i_target_id,
    input  wire logic [31:0] i_sleep_ms,
    output logic             o_valid,
    input  wire logic        i_stall,
    output logic             o_status,
    output logic [15:0]      o_new_task_id,
    output logic [2:0]       o_running_slot,
    output logic [15:0]      o_running_id,
    output logic             o_switched,
    output logic [63:0]      o_next_context,
    output logic [63:0]      o_next_user_stack,
    output logic             o_restore_user_stack
);

    rrts_pkg::t_cmd  cmd;
    rrts_pkg::t_stat stat;

    rrts_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_stat  (stat),
        .o_cmd   (cmd)
    );

    rrts_dpath #(.TASK_SLOTS(TASK_SLOTS)) u_dpath (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_cmd                (cmd),
        .o_stat               (stat),
        .i_opcode             (i_opcode),
        .i_now_tick           (i_now_tick),
        .i_context_word       (i_context_word),
        .i_user_stack_word    (i_user_stack_word),
        .i_target_id          (i_target_id),
        .i_sleep_ms           (i_sleep_ms),
        .o_status             (o_status),
        .o_new_task_id        (o_new_task_id),
        .o_running_slot       (o_running_slot),
        .o_running_id         (o_running_id),
        .o_switched           (o_switched),
        .o_next_context       (o_next_context),
        .o_next_user_stack    (o_next_user_stack),
        .o_restore_user_stack (o_restore_user_stack)
    );

endmodule
`default_nettype wire

// ===== design/rrts_checker.sv =====
// Port-level checker for the round-robin task scheduler unit, bound to the top.
// Depends on round_robin_task_scheduler_unit_defines.svh.
`default_nettype none
`include "round_robin_task_scheduler_unit_defines.svh"
module rrts_checker (
    input wire logic        i_clk,
    input wire logic        i_rst_n,
    input wire logic        i_valid,
    input wire logic        o_stall,
    input wire logic [2:0]  i_opcode,
    input wire logic [47:0] i_now_tick,
    input wire logic [63:0] i_context_word,
    input wire logic [63:0] i_user_stack_word,
    input wire logic [15:0] i_target_id,
    input wire logic [31:0] i_sleep_ms,
    input wire logic        o_valid,
    input wire logic        i_stall,
    input wire logic        o_status,
    input wire logic [15:0] o_new_task_id,
    input wire logic [2:0]  o_running_slot,
    input wire logic [15:0] o_running_id,
    input wire logic        o_switched,
    input wire logic [63:0] o_next_context,
    input wire logic [63:0] o_next_user_stack,
    input wire logic        o_restore_user_stack
);

    `RRTS_ASSERT_NEXT(a_valid_holds, o_valid && i_stall, o_valid)
    `RRTS_ASSERT_NEXT(a_beat_holds, o_valid && i_stall, $stable(o_running_id))
    `RRTS_ASSERT_NOW(a_refuse_clean, o_valid && o_status,
        (o_new_task_id == 16'd0) && !o_switched && (o_next_context == 64'd0))
    `RRTS_ASSERT_NOW(a_restore_stack, o_valid && o_restore_user_stack,
        o_next_user_stack != 64'd0)

endmodule

bind round_robin_task_scheduler_unit rrts_checker u_rrts_checker (.*);
`default_nettype wire

// ===== tb/sv/tb_round_robin_task_scheduler_unit.sv =====
// Testbench for the round-robin task scheduler unit: random and directed events
// are checked against a behavioral scheduler model. Depends on rrts_pkg and the RTL.
`default_nettype none
module tb_round_robin_task_scheduler_unit;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int NS = rrts_pkg::TASK_SLOTS_DEF;
    localparam int NIL = NS;
    localparam logic [47:0] TICK_MAX = 48'hFFFF_FFFF_FFFF;
    localparam int CYCLE_LIMIT = 400000;
    localparam logic [2:0] OP_UNDEFINED = 3'd7;

    typedef struct packed {
        logic [2:0]  op;
        logic [47:0] now;
        logic [63:0] ctx;
        logic [63:0] ustk;
        logic [15:0] tid;
        logic [31:0] ms;
    } t_event;

    typedef struct packed {
        logic        status;
        logic [15:0] new_id;
        logic [2:0]  run_slot;
        logic [15:0] run_id;
        logic        switched;
        logic [63:0] nctx;
        logic [63:0] nustk;
        logic        restore;
    } t_outcome;

    logic i_clk = 1'b0;
    logic i_rst_n = 1'b0;
    logic i_valid = 1'b0;
    logic o_stall;
    logic [2:0] i_opcode = '0;
    logic [47:0] i_now_tick = '0;
    logic [63:0] i_context_word = '0;
    logic [63:0] i_user_stack_word = '0;
    logic [15:0] i_target_id = '0;
    logic [31:0] i_sleep_ms = '0;
    logic o_valid;
    logic i_stall = 1'b1;
    logic o_status;
    logic [15:0] o_new_task_id;
    logic [2:0] o_running_slot;
    logic [15:0] o_running_id;
    logic o_switched;
    logic [63:0] o_next_context;
    logic [63:0] o_next_user_stack;
    logic o_restore_user_stack;

    round_robin_task_scheduler_unit u_dut (.*);

    always #2 i_clk = ~i_clk;

    logic [1:0]  m_status [NS];
    logic [15:0] m_id [NS];
    logic        m_user [NS];
    logic [63:0] m_ctx [NS];
    logic [63:0] m_ustk [NS];
    logic [47:0] m_wake [NS];
    int          m_link [NS];
    int m_head, m_tail, m_cur;
    logic [15:0] m_next_id;

    t_event   pending_events [$];
    t_outcome expected_outcomes [$];
    int mismatches = 0;
    int cycles = 0;
    int gap = 0;
    int hold = 0;
    bit stim_done = 0;
    bit drain_req = 0;
    logic [47:0] tick_now = 0;

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(10, 40);
    endfunction

    function automatic void sched_reset();
        for (int i = 0; i < NS; i++) begin
            m_status[i] = rrts_pkg::ST_DEAD; m_id[i] = 0; m_user[i] = 0; m_ctx[i] = 0;
            m_ustk[i] = 0; m_wake[i] = 0; m_link[i] = NIL;
        end
        m_status[0] = rrts_pkg::ST_RUNNING;
        m_head = NIL; m_tail = NIL; m_cur = 0; m_next_id = 1;
    endfunction

    function automatic void list_push(int s);
        m_link[s] = NIL;
        if (m_head == NIL) m_head = s;
        else if (m_tail < NS) m_link[m_tail] = s;
        m_tail = s;
    endfunction

    function automatic void list_unlink(int p, int s);
        int nx;
        nx = m_link[s];
        if (p == NIL) m_head = nx; else m_link[p] = nx;
        if (m_tail == s) m_tail = p;
        m_link[s] = NIL;
    endfunction

    function automatic void list_remove(int s);
        int p, c;
        p = NIL; c = m_head;
        for (int n = 0; n < NS && c < NS; n++) begin
            if (c == s) begin
                list_unlink(p, c);
                return;
            end
            p = c; c = m_link[c];
        end
    endfunction

    function automatic int take_ready(logic [47:0] now);
        int p, c;
        p = NIL; c = m_head;
        for (int n = 0; n < NS && c < NS; n++) begin
            if (m_status[c] == rrts_pkg::ST_BLOCKED && now >= m_wake[c])
                m_status[c] = rrts_pkg::ST_READY;
            if (m_status[c] == rrts_pkg::ST_READY) begin
                list_unlink(p, c);
                return c;
            end
            p = c; c = m_link[c];
        end
        return NIL;
    endfunction

    function automatic void do_preempt(t_event e, inout t_outcome o);
        int prev, nx;
        prev = m_cur;
        m_ctx[prev] = e.ctx;
        if (m_user[prev]) m_ustk[prev] = e.ustk;
        if (m_status[prev] == rrts_pkg::ST_RUNNING) begin
            m_status[prev] = rrts_pkg::ST_READY;
            list_push(prev);
        end
        nx = take_ready(e.now);
        if (nx == NIL) begin
            list_remove(prev);
            m_status[prev] = rrts_pkg::ST_RUNNING;
            o.nctx = m_ctx[prev]; o.nustk = m_ustk[prev];
            return;
        end
        m_cur = nx;
        m_status[nx] = rrts_pkg::ST_RUNNING;
        o.switched = (nx != prev);
        o.nctx = m_ctx[nx]; o.nustk = m_ustk[nx];
        o.restore = m_user[nx] && m_ustk[nx] != 0;
    endfunction

    function automatic t_outcome schedule_event(t_event e);
        t_outcome o;
        int s;
        logic [48:0] wake;
        o = '0;
        s = NIL;
        case (e.op)
            rrts_pkg::OP_PREEMPT: do_preempt(e, o);
            rrts_pkg::OP_CREATE_USER, rrts_pkg::OP_CREATE_KERNEL: begin
                for (int i = 0; i < NS; i++)
                    if (s == NIL && m_status[i] == rrts_pkg::ST_DEAD) s = i;
                if (s == NIL) o.status = 1;
                else begin
                    m_id[s] = m_next_id; m_next_id++;
                    m_status[s] = rrts_pkg::ST_READY; m_wake[s] = 0;
                    m_user[s] = (e.op == rrts_pkg::OP_CREATE_USER);
                    m_ctx[s] = e.ctx;
                    m_ustk[s] = (e.op == rrts_pkg::OP_CREATE_USER) ? e.ustk : 64'd0;
                    list_push(s);
                    o.new_id = m_id[s];
                end
            end
            rrts_pkg::OP_KILL: begin
                for (int i = 0; i < NS; i++)
                    if (s == NIL && m_id[i] == e.tid && m_status[i] != rrts_pkg::ST_DEAD) s = i;
                if (s == NIL || s == 0 || s == m_cur) o.status = 1;
                else begin
                    list_remove(s);
                    m_status[s] = rrts_pkg::ST_DEAD;
                end
            end
            rrts_pkg::OP_SLEEP: begin
                if (m_status[m_cur] == rrts_pkg::ST_RUNNING) begin
                    wake = {1'b0, e.now} + ((49'(e.ms) + 49'd99) / 49'd100);
                    m_wake[m_cur] = (wake > {1'b0, TICK_MAX}) ? TICK_MAX : wake[47:0];
                    m_status[m_cur] = rrts_pkg::ST_BLOCKED;
                    list_push(m_cur);
                end
            end
            rrts_pkg::OP_EXIT: begin
                list_remove(m_cur);
                m_status[m_cur] = rrts_pkg::ST_DEAD;
            end
            rrts_pkg::OP_FAULT: begin
                list_remove(m_cur);
                m_status[m_cur] = rrts_pkg::ST_DEAD;
                do_preempt(e, o);
            end
            default: ;
        endcase
        o.run_slot = m_cur[2:0];
        o.run_id = m_id[m_cur];
        return o;
    endfunction

    function automatic t_event rand_event(logic [2:0] op);
        t_event e;
        int r;
        e.op = op;
        r = $urandom_range(0, 9);
        tick_now = tick_now + $urandom_range(0, 3);
        e.now = (r == 0) ? 48'({$urandom, $urandom}) : tick_now;
        e.ctx = {$urandom, $urandom};
        e.ustk = ($urandom_range(0, 5) == 0) ? 64'd0 : {$urandom, $urandom};
        r = $urandom_range(0, 3);
        e.tid = (r == 0) ? 16'($urandom) : 16'(m_next_id - $urandom_range(1, 12));
        r = $urandom_range(0, 5);
        e.ms = (r == 0) ? $urandom : (r == 1) ? 32'hFFFF_FFFF : $urandom_range(0, 500);
        return e;
    endfunction

    function automatic logic [2:0] rand_op();
        int r;
        r = $urandom_range(0, 99);
        if (r < 35) return rrts_pkg::OP_PREEMPT;
        if (r < 50) return rrts_pkg::OP_CREATE_USER;
        if (r < 60) return rrts_pkg::OP_CREATE_KERNEL;
        if (r < 72) return rrts_pkg::OP_KILL;
        if (r < 84) return rrts_pkg::OP_SLEEP;
        if (r < 91) return rrts_pkg::OP_EXIT;
        if (r < 98) return rrts_pkg::OP_FAULT;
        return OP_UNDEFINED;
    endfunction

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else if (i_valid && !o_stall) begin
            if (gap == 0 && hold == 0 && !drain_req && pending_events.size() > 0) begin
                i_opcode <= pending_events[0].op;
                i_now_tick <= pending_events[0].now;
                i_context_word <= pending_events[0].ctx;
                i_user_stack_word <= pending_events[0].ustk;
                i_target_id <= pending_events[0].tid;
                i_sleep_ms <= pending_events[0].ms;
                expected_outcomes.push_back(schedule_event(pending_events.pop_front()));
                gap <= pick_gap();
            end else begin
                i_valid <= 1'b0;
            end
        end else if (!i_valid) begin
            if (gap > 0) begin
                gap <= gap - 1;
            end else if (drain_req && expected_outcomes.size() == 0) begin
                drain_req <= 1'b0;
            end else if (!drain_req && pending_events.size() > 0) begin
                i_valid <= 1'b1;
                i_opcode <= pending_events[0].op;
                i_now_tick <= pending_events[0].now;
                i_context_word <= pending_events[0].ctx;
                i_user_stack_word <= pending_events[0].ustk;
                i_target_id <= pending_events[0].tid;
                i_sleep_ms <= pending_events[0].ms;
                expected_outcomes.push_back(schedule_event(pending_events.pop_front()));
                gap <= pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin
        t_outcome act, exp_o;
        cycles <= cycles + 1;
        if (!i_rst_n) begin
            i_stall <= 1'b1;
        end else begin
            if (o_valid && !i_stall) begin
                act = '{o_status, o_new_task_id, o_running_slot, o_running_id, o_switched,
                        o_next_context, o_next_user_stack, o_restore_user_stack};
                if (expected_outcomes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10) $display("Unexpected result beat: %h", act);
                end else begin
                    exp_o = expected_outcomes.pop_front();
                    if (act !== exp_o) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display("Mismatch: expected %h actual %h", exp_o, act);
                    end
                end
            end
            if (hold > 0) begin
                hold <= hold - 1;
                i_stall <= 1'b1;
            end else begin
                i_stall <= ($urandom_range(0, 99) < 30);
                if ($urandom_range(0, 99) < 3) hold <= $urandom_range(10, 40);
            end
        end
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAILURE");
            $finish;
        end
    end

    initial begin
        t_event e;
        sched_reset();
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        for (int i = 0; i < 9; i++) begin
            e = rand_event(i[0] ? rrts_pkg::OP_CREATE_USER : rrts_pkg::OP_CREATE_KERNEL);
            if (i == 0) begin e.ctx = '1; e.ustk = '1; end
            pending_events.push_back(e);
        end
        e = rand_event(rrts_pkg::OP_KILL); e.tid = 0; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_KILL); e.tid = 16'hFFFF; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_KILL); e.tid = 3; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_PREEMPT); e.now = 0; e.ctx = 0; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_KILL); e.tid = 2; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_SLEEP); e.ms = 32'hFFFF_FFFF; e.now = TICK_MAX;
        pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_SLEEP); pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_PREEMPT); e.now = TICK_MAX; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_EXIT); pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_CREATE_USER); pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_PREEMPT); pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_FAULT); pending_events.push_back(e);
        e = rand_event(OP_UNDEFINED); e.ms = 1; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_SLEEP); e.ms = 0; pending_events.push_back(e);
        e = rand_event(rrts_pkg::OP_PREEMPT); pending_events.push_back(e);
        for (int i = 0; i < 550; i++) begin
            if (i == 270) begin
                wait (pending_events.size() == 0);
                drain_req = 1;
                wait (drain_req == 0);
            end
            pending_events.push_back(rand_event(rand_op()));
        end
        wait (pending_events.size() == 0 && !i_valid && expected_outcomes.size() == 0);
        repeat (60) @(posedge i_clk);
        if (mismatches == 0 && expected_outcomes.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end
endmodule
`default_nettype wire

// ===== round_robin_task_scheduler_unit.f =====
+incdir+design
design/rrts_pkg.sv
design/rrts_ram.sv
design/rrts_ctrl.sv
design/rrts_dpath.sv
design/round_robin_task_scheduler_unit.sv
design/rrts_checker.sv
tb/sv/tb_round_robin_task_scheduler_unit.sv
